@@ design/mwrb_pkg.sv @@
// ----------------------------------------------------------------------------
// mwrb_pkg
// Shared types and constants for the multi-word event ring buffer.
// ----------------------------------------------------------------------------
`default_nettype none

package mwrb_pkg;

  localparam int WordW    = 32;
  localparam int IoWords  = 4;
  localparam int OpW      = 2;
  localparam int StatusW  = 2;
  localparam int InDataW  = 136;  // op + 4 words = 130 bits, padded to bytes
  localparam int OutDataW = 136;  // 4 words + status + empty = 131 bits, padded
  localparam int OutUsedW = IoWords * WordW + StatusW + 1;

  localparam int SlotCntW = 5;
  localparam int SlotWrdW = 3;
  localparam int CfgIdxW  = 1;
  localparam int CfgDataW = 5;

  localparam logic [SlotCntW-1:0] SlotCntRst = 5'd16;
  localparam logic [SlotWrdW-1:0] SlotWrdRst = 3'd4;

  localparam logic [CfgIdxW-1:0] RegSlotCount = 1'b0;
  localparam logic [CfgIdxW-1:0] RegSlotWords = 1'b1;

  typedef enum logic [OpW-1:0] {
    OP_ENQ = 2'd0,
    OP_OVW = 2'd1,
    OP_DEQ = 2'd2,
    OP_NOP = 2'd3
  } op_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_e;

  // per-beat command fanned out to every lane
  typedef struct packed {
    logic acc;  // input beat taken this cycle
    logic wr;   // store the beat's words
    logic rd;   // read the oldest slot (successful dequeue)
  } lane_cmd_t;

endpackage

`default_nettype wire

@@ design/mwrb_ram.sv @@
// ----------------------------------------------------------------------------
// mwrb_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module mwrb_ram #(
  parameter int Width = 32,
  parameter int Depth = 16,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ design/mwrb_lane.sv @@
// ----------------------------------------------------------------------------
// mwrb_lane
// One word lane: slot storage for a single word position, lane enable
// against the configured word count, and zeroing of unused read words.
// ----------------------------------------------------------------------------
`default_nettype none

module mwrb_lane #(
  parameter int LaneIdx = 0,
  parameter int Depth   = 16,
  localparam int AddrW  = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire mwrb_pkg::lane_cmd_t           cmd_i,
  input  wire logic [mwrb_pkg::SlotWrdW-1:0] used_words_i,
  input  wire logic [AddrW-1:0]              waddr_i,
  input  wire logic [AddrW-1:0]              raddr_i,
  input  wire logic [mwrb_pkg::WordW-1:0]    wdata_i,
  output logic      [mwrb_pkg::WordW-1:0]    data_o
);
  import mwrb_pkg::*;

  logic             lane_on;
  logic             keep_q;
  logic [WordW-1:0] rdata;

  assign lane_on = (used_words_i > SlotWrdW'(LaneIdx));

  mwrb_ram #(
    .Width(WordW),
    .Depth(Depth)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (cmd_i.wr && lane_on),
    .waddr_i(waddr_i),
    .wdata_i(wdata_i),
    .re_i   (cmd_i.rd),
    .raddr_i(raddr_i),
    .rdata_o(rdata)
  );

  // keep flag follows the read data: set only for a dequeue that uses this lane
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      keep_q <= 1'b0;
    end else if (cmd_i.acc) begin
      keep_q <= cmd_i.rd && lane_on;
    end
  end

  assign data_o = keep_q ? rdata : '0;

endmodule

`default_nettype wire

@@ design/multiword_event_ring_buffer_unit.sv @@
// Pipeline: a taken input beat passes the slot RAM read stage, then the
//   output register, before its result beat is presented.
// Throughput: one operation per cycle; the single slot access per beat in
//   each lane RAM sets this, and output back-pressure stalls the input side.
// Reset: asynchronous, active low; clears the queue to empty with both
//   indices at slot 0 and restores slot_count=16, slot_words=4. Slot RAM
//   contents are not cleared.
// ----------------------------------------------------------------------------
// multiword_event_ring_buffer_unit
// Circular event queue with overwrite. Each slot holds up to four 32-bit
// words kept in parallel word lanes; a merge stage packs lane read data
// with status and the empty flag into the result beat.
// ----------------------------------------------------------------------------
`default_nettype none

module multiword_event_ring_buffer_unit #(
  parameter int MAX_SLOTS = 16,
  parameter int MAX_WORDS = 4
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // configuration write port
  input  wire logic                          cfg_we_i,
  input  wire logic [mwrb_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [mwrb_pkg::CfgDataW-1:0] cfg_data_i,
  // input stream
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  // tdata: op[1:0], in_word0[33:2], in_word1[65:34], in_word2[97:66],
  //        in_word3[129:98], zero pad[135:130]
  input  wire logic [mwrb_pkg::InDataW-1:0]  s_axis_tdata,
  // result stream
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  // tdata: out_word0[31:0], out_word1[63:32], out_word2[95:64],
  //        out_word3[127:96], status[129:128], now_empty[130], zero pad[135:131]
  output logic      [mwrb_pkg::OutDataW-1:0] m_axis_tdata
);
  import mwrb_pkg::*;

  localparam int IdxW  = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int CntW  = (IdxW + 1 > SlotCntW) ? IdxW + 1 : SlotCntW;
  localparam int Lanes = (MAX_WORDS < IoWords) ? MAX_WORDS : IoWords;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [SlotCntW-1:0] slot_count_q;
  logic [SlotWrdW-1:0] slot_words_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_count_q <= SlotCntRst;
      slot_words_q <= SlotWrdRst;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        RegSlotCount: slot_count_q <= cfg_data_i;
        RegSlotWords: slot_words_q <= cfg_data_i[SlotWrdW-1:0];
        default: ;
      endcase
    end
  end

  // Effective counts: zero acts as one, large values clip to the hardware limit
  logic [CntW-1:0]     used_slots;
  logic [SlotWrdW-1:0] used_words;

  always_comb begin
    used_slots = CntW'(slot_count_q);
    if (used_slots == '0) begin
      used_slots = CntW'(1);
    end else if (used_slots > CntW'(MAX_SLOTS)) begin
      used_slots = CntW'(MAX_SLOTS);
    end
    used_words = slot_words_q;
    if (used_words == '0) begin
      used_words = SlotWrdW'(1);
    end else if (used_words > SlotWrdW'(Lanes)) begin
      used_words = SlotWrdW'(Lanes);
    end
  end

  // --------------------------------------------------------------------------
  // Queue state and handshake
  // --------------------------------------------------------------------------
  logic [IdxW-1:0] newest_q, newest_d;
  logic [IdxW-1:0] oldest_q, oldest_d;
  logic            empty_q, empty_d;

  logic            pend_q, pend_d;        // read stage occupied
  logic [StatusW-1:0] pend_status_q, pend_status_d;
  logic            pend_empty_q, pend_empty_d;

  logic            out_valid_q, out_valid_d;
  logic [OutUsedW-1:0] out_q, out_d;

  logic            acc;
  logic            move;

  assign move          = pend_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !pend_q || move;
  assign acc           = s_axis_tvalid && s_axis_tready;

  op_e op;
  assign op = op_e'(s_axis_tdata[OpW-1:0]);

  // Advance with wrap; an index at or past the last used slot wraps to zero
  logic [CntW-1:0] newest_inc, oldest_inc;
  logic [IdxW-1:0] newest_nxt, oldest_nxt;

  assign newest_inc = CntW'(newest_q) + CntW'(1);
  assign oldest_inc = CntW'(oldest_q) + CntW'(1);
  assign newest_nxt = (newest_inc >= used_slots) ? '0 : newest_inc[IdxW-1:0];
  assign oldest_nxt = (oldest_inc >= used_slots) ? '0 : oldest_inc[IdxW-1:0];

  lane_cmd_t       cmd;
  logic [IdxW-1:0] waddr;
  status_e         status;

  always_comb begin
    newest_d = newest_q;
    oldest_d = oldest_q;
    empty_d  = empty_q;
    status   = ST_OK;
    waddr    = newest_q;
    cmd      = '0;
    cmd.acc  = acc;
    unique case (op)
      OP_ENQ: begin
        if (empty_q) begin
          empty_d = 1'b0;
          cmd.wr  = acc;
        end else if (newest_nxt == oldest_q) begin
          status = ST_OVERFLOW;
        end else begin
          newest_d = newest_nxt;
          waddr    = newest_nxt;
          cmd.wr   = acc;
        end
      end
      OP_OVW: begin
        empty_d = 1'b0;
        cmd.wr  = acc;
      end
      OP_DEQ: begin
        if (empty_q) begin
          status = ST_UNDERFLOW;
        end else begin
          cmd.rd = acc;
          if (newest_q == oldest_q) begin
            empty_d = 1'b1;
          end else begin
            oldest_d = oldest_nxt;
          end
        end
      end
      OP_NOP: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      newest_q <= '0;
      oldest_q <= '0;
      empty_q  <= 1'b1;
    end else if (acc) begin
      newest_q <= newest_d;
      oldest_q <= oldest_d;
      empty_q  <= empty_d;
    end
  end

  // --------------------------------------------------------------------------
  // Word lanes
  // --------------------------------------------------------------------------
  logic [WordW-1:0] lane_data [IoWords];

  for (genvar l = 0; l < IoWords; l++) begin : g_lane
    if (l < Lanes) begin : g_on
      mwrb_lane #(
        .LaneIdx(l),
        .Depth  (MAX_SLOTS)
      ) u_lane (
        .clk_i       (clk_i),
        .rst_ni      (rst_ni),
        .cmd_i       (cmd),
        .used_words_i(used_words),
        .waddr_i     (waddr),
        .raddr_i     (oldest_q),
        .wdata_i     (s_axis_tdata[OpW + WordW*l +: WordW]),
        .data_o      (lane_data[l])
      );
    end else begin : g_off
      assign lane_data[l] = '0;
    end
  end

  // --------------------------------------------------------------------------
  // Read stage metadata and merge into the output register
  // --------------------------------------------------------------------------
  always_comb begin
    pend_d        = pend_q;
    pend_status_d = pend_status_q;
    pend_empty_d  = pend_empty_q;
    if (acc) begin
      pend_d        = 1'b1;
      pend_status_d = status;
      pend_empty_d  = empty_d;
    end else if (move) begin
      pend_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (move) begin
      out_valid_d = 1'b1;
      out_d       = {pend_empty_q, pend_status_q,
                     lane_data[3], lane_data[2], lane_data[1], lane_data[0]};
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_status_q <= pend_status_d;
    pend_empty_q  <= pend_empty_d;
    out_q         <= out_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {(OutDataW - OutUsedW)'(0), out_q};

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // an empty queue always has both indices on the same slot
  a_empty_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty_q |-> (newest_q == oldest_q))
    else $error("empty queue with split indices");

  // underflow is only reported while the queue stays empty
  a_uflow_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tdata[129:128] == ST_UNDERFLOW)) |-> m_axis_tdata[130])
    else $error("underflow reported on non-empty queue");

  // a refused enqueue means the queue was full, hence not empty
  a_oflow_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tdata[129:128] == ST_OVERFLOW)) |-> !m_axis_tdata[130])
    else $error("overflow reported on empty queue");

  // a stalled read stage keeps the RAM read data: no new beat may enter
  a_pend_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pend_q && out_valid_q && !m_axis_tready) |-> !s_axis_tready)
    else $error("input taken while read stage is stalled");

endmodule

`default_nettype wire
